// File: hdl/eihp_pkg.sv
// Package for the Ethernet/IPv4 header parser: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package eihp_pkg;

    localparam logic [15:0] ET_IP  = 16'h0800;
    localparam logic [15:0] ET_ARP = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  ARP_REQUEST = 8'd1;
    localparam logic [15:0] MAX_IP_RESET = 16'd3000;

    // bit positions in the TCP flag byte
    localparam int TCP_FIN_BIT = 0;
    localparam int TCP_SYN_BIT = 1;
    localparam int TCP_ACK_BIT = 4;

    typedef enum logic [2:0] {
        PT_UNKNOWN = 3'd0,
        PT_ARP     = 3'd1,
        PT_ICMP    = 3'd2,
        PT_TCP     = 3'd3,
        PT_UDP     = 3'd4,
        PT_OTHER   = 3'd5
    } ptype_t;

    // One result record as it travels between front and back.
    typedef struct packed {
        logic         is_summary;
        logic [7:0]   text_char;
        logic [2:0]   packet_type;
        logic [47:0]  mac_first;
        logic [47:0]  mac_second;
        logic [47:0]  arp_hw_addr;
        logic [31:0]  ip_source;
        logic [31:0]  ip_target;
        logic [7:0]   protocol;
        logic [31:0]  ports;
        logic [31:0]  ident_frag;
        logic [4:0]   flags;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

endpackage

// File: hdl/eihp_front.sv
// Front end: byte counter, field capture, classification, up to two records per byte.
// Depends on eihp_pkg.
`timescale 1ns / 1ps
module eihp_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [7:0]              frame_byte,
    input  logic                    frame_end,
    input  logic [15:0]             max_ip_length,
    output logic                    text_valid,
    output eihp_pkg::result_t       text_rec,
    output logic                    sum_valid,
    output eihp_pkg::result_t       sum_rec
);
    import eihp_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0] etype_reg, etype_next;
    logic [5:0]  iphl_reg, iphl_next;
    logic [15:0] iplen_reg, iplen_next;
    logic [5:0]  l4hl_reg, l4hl_next;
    logic [7:0]  arpop_reg, arpop_next;
    logic [47:0] mac0_reg, mac1_reg, arphw_reg;
    logic [47:0] mac0_next, mac1_next, arphw_next;
    logic [31:0] src_reg, dst_reg, ports_reg;
    logic [31:0] src_next, dst_next, ports_next;
    logic [15:0] ident_reg, fragw_reg;
    logic [15:0] ident_next, fragw_next;
    logic [7:0]  proto_reg, tcpf_reg;
    logic [7:0]  proto_next, tcpf_next;

    logic        active;
    logic [16:0] pos17;
    logic [16:0] l4_start, pay_start, pay_end;
    logic [16:0] rel;
    logic        is_l4;
    logic [5:0]  hl_ip, hl_tcp;
    logic [15:0] tlen;

    // narrow positions (only meaningful when pos < 64)
    logic [5:0] p6;
    logic       low_pos;

    assign active   = (pos_reg != POS_MAX);
    assign pos17    = 17'(pos_reg);
    assign p6       = pos_reg[5:0];
    assign l4_start = 17'd14 + 17'(iphl_reg);
    assign pay_start = l4_start + 17'(l4hl_reg);
    assign pay_end  = 17'd14 + 17'(iplen_reg);
    assign rel      = pos17 - l4_start;
    assign is_l4    = (etype_reg == ET_IP) && (proto_reg == PROTO_TCP || proto_reg == PROTO_UDP);
    assign hl_ip    = {frame_byte[3:0], 2'b00};
    assign hl_tcp   = {frame_byte[7:4], 2'b00};
    assign tlen     = {iplen_reg[15:8], frame_byte};
    assign low_pos  = (pos_reg < POSITION_BITS'(64));

    // Field values after the byte on the input has been taken.
    always_comb
    begin
        pos_next   = pos_reg;
        etype_next = etype_reg;
        iphl_next  = iphl_reg;
        iplen_next = iplen_reg;
        l4hl_next  = l4hl_reg;
        arpop_next = arpop_reg;
        mac0_next  = mac0_reg;
        mac1_next  = mac1_reg;
        arphw_next = arphw_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ports_next = ports_reg;
        ident_next = ident_reg;
        fragw_next = fragw_reg;
        proto_next = proto_reg;
        tcpf_next  = tcpf_reg;
        if (active)
        begin
            pos_next = pos_reg + 1'b1;
            if (low_pos && p6 < 6'd6)
                mac0_next[(3'd5 - p6[2:0])*8 +: 8] = frame_byte;
            else if (low_pos && p6 < 6'd12)
                mac1_next[(4'd11 - p6[3:0])*8 +: 8] = frame_byte;
            else if (low_pos && p6 == 6'd12)
                etype_next[15:8] = frame_byte;
            else if (low_pos && p6 == 6'd13)
                etype_next[7:0] = frame_byte;
            else if (etype_reg == ET_ARP)
            begin
                if (low_pos && p6 == 6'd21)
                begin
                    proto_next = frame_byte;
                    arpop_next = frame_byte;
                end
                else if (low_pos && p6 >= 6'd22 && p6 <= 6'd27)
                    arphw_next[(6'd27 - p6)*8 +: 8] = frame_byte;
                else if (low_pos && p6 >= 6'd28 && p6 <= 6'd31 && arpop_reg != ARP_REQUEST)
                    dst_next[(6'd31 - p6)*8 +: 8] = frame_byte;
                else if (low_pos && p6 >= 6'd38 && p6 <= 6'd41 && arpop_reg == ARP_REQUEST)
                    dst_next[(6'd41 - p6)*8 +: 8] = frame_byte;
            end
            else if (etype_reg == ET_IP)
            begin
                if (low_pos && p6 == 6'd14)
                    iphl_next = (hl_ip < 6'd20) ? 6'd20 : hl_ip;
                else if (low_pos && p6 == 6'd16)
                    iplen_next = {frame_byte, 8'h00};
                else if (low_pos && p6 == 6'd17)
                    iplen_next = (tlen > max_ip_length) ? max_ip_length : tlen;
                else if (low_pos && p6 == 6'd18)
                    ident_next[15:8] = frame_byte;
                else if (low_pos && p6 == 6'd19)
                    ident_next[7:0] = frame_byte;
                else if (low_pos && p6 == 6'd20)
                    fragw_next[15:8] = frame_byte;
                else if (low_pos && p6 == 6'd21)
                    fragw_next[7:0] = frame_byte;
                else if (low_pos && p6 == 6'd23)
                begin
                    proto_next = frame_byte;
                    l4hl_next  = (frame_byte == PROTO_UDP) ? 6'd8 : 6'd20;
                end
                else if (low_pos && p6 >= 6'd26 && p6 <= 6'd29)
                    src_next[(6'd29 - p6)*8 +: 8] = frame_byte;
                else if (low_pos && p6 >= 6'd30 && p6 <= 6'd33)
                    dst_next[(6'd33 - p6)*8 +: 8] = frame_byte;
                else if (is_l4 && pos17 >= l4_start)
                begin
                    if (rel < 17'd4)
                        ports_next[(2'd3 - rel[1:0])*8 +: 8] = frame_byte;
                    else if (proto_reg == PROTO_TCP && rel == 17'd12)
                        l4hl_next = (hl_tcp < 6'd20) ? 6'd20 : hl_tcp;
                    else if (proto_reg == PROTO_TCP && rel == 17'd13)
                        tcpf_next = frame_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            etype_reg <= '0;
            iphl_reg  <= 6'd20;
            iplen_reg <= '0;
            l4hl_reg  <= 6'd20;
            arpop_reg <= '0;
            mac0_reg  <= '0;
            mac1_reg  <= '0;
            arphw_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            ports_reg <= '0;
            ident_reg <= '0;
            fragw_reg <= '0;
            proto_reg <= '0;
            tcpf_reg  <= '0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                pos_reg   <= '0;
                etype_reg <= '0;
                iphl_reg  <= 6'd20;
                iplen_reg <= '0;
                l4hl_reg  <= 6'd20;
                arpop_reg <= '0;
                mac0_reg  <= '0;
                mac1_reg  <= '0;
                arphw_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                ports_reg <= '0;
                ident_reg <= '0;
                fragw_reg <= '0;
                proto_reg <= '0;
                tcpf_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                etype_reg <= etype_next;
                iphl_reg  <= iphl_next;
                iplen_reg <= iplen_next;
                l4hl_reg  <= l4hl_next;
                arpop_reg <= arpop_next;
                mac0_reg  <= mac0_next;
                mac1_reg  <= mac1_next;
                arphw_reg <= arphw_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                ports_reg <= ports_next;
                ident_reg <= ident_next;
                fragw_reg <= fragw_next;
                proto_reg <= proto_next;
                tcpf_reg  <= tcpf_next;
            end
        end
    end

    // Payload text: only once the fixed header positions are behind us.
    logic hdr_zone;
    assign hdr_zone = low_pos && p6 <= 6'd33;

    always_comb
    begin
        text_rec = '0;
        text_rec.text_char = (frame_byte >= 8'h20 && frame_byte <= 8'h7E) ? frame_byte : 8'h2E;
        text_valid = take && active && !hdr_zone && is_l4
                     && pos17 >= pay_start && pos17 < pay_end;
    end

    // Frame summary, built from the field values that include the closing byte.
    logic [15:0] foff;
    ptype_t      ptype;
    always_comb
    begin
        foff  = {fragw_next[12:0], 3'b000};
        ptype = PT_UNKNOWN;
        if (pos_next >= POSITION_BITS'(14))
        begin
            if (etype_next == ET_ARP)
                ptype = PT_ARP;
            else if (etype_next == ET_IP)
            begin
                case (proto_next)
                    PROTO_ICMP: ptype = PT_ICMP;
                    PROTO_TCP:  ptype = PT_TCP;
                    PROTO_UDP:  ptype = PT_UDP;
                    default:    ptype = PT_OTHER;
                endcase
            end
        end
        sum_rec = '0;
        sum_rec.is_summary  = 1'b1;
        sum_rec.packet_type = ptype;
        sum_rec.mac_first   = mac0_next;
        sum_rec.mac_second  = mac1_next;
        if (ptype == PT_ARP)
        begin
            sum_rec.arp_hw_addr = arphw_next;
            sum_rec.ip_target   = dst_next;
            sum_rec.protocol    = proto_next;
        end
        else if (ptype != PT_UNKNOWN)
        begin
            sum_rec.ip_source  = src_next;
            sum_rec.ip_target  = dst_next;
            sum_rec.protocol   = proto_next;
            if (ptype == PT_TCP || ptype == PT_UDP)
                sum_rec.ports = ports_next;
            sum_rec.ident_frag = {ident_next, foff};
            sum_rec.flags[0]   = fragw_next[13];
            sum_rec.flags[1]   = fragw_next[13] || (foff != 16'h0000);
            if (ptype == PT_TCP)
            begin
                sum_rec.flags[2] = tcpf_next[TCP_SYN_BIT];
                sum_rec.flags[3] = tcpf_next[TCP_ACK_BIT];
                sum_rec.flags[4] = tcpf_next[TCP_FIN_BIT];
            end
        end
        sum_valid = take && frame_end;
    end
endmodule

// File: hdl/eihp_fifo.sv
// Short result queue between front and back; two writes per cycle allowed.
// Depends on eihp_pkg.
`timescale 1ns / 1ps
module eihp_fifo #(
    parameter int DEPTH_BITS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr0,
    input  eihp_pkg::result_t d0,
    input  logic              wr1,
    input  eihp_pkg::result_t d1,
    input  logic              rd,
    output logic              nonempty,
    output logic              almost_full,
    output eihp_pkg::result_t q
);
    import eihp_pkg::*;

    localparam int DEPTH = 1 << DEPTH_BITS;

    result_t mem [DEPTH];
    logic [DEPTH_BITS-1:0] wp_reg, rp_reg;
    logic [DEPTH_BITS:0]   cnt_reg;
    logic [DEPTH_BITS-1:0] wp1;
    logic [1:0]            nwr;

    assign wp1 = wp_reg + 1'b1;
    assign nwr = {1'b0, wr0} + {1'b0, wr1};
    assign nonempty = (cnt_reg != '0);
    // room for two more after one still in flight
    assign almost_full = (cnt_reg > (DEPTH_BITS+1)'(DEPTH - 4));
    assign q = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr0)
            mem[wp_reg] <= d0;
        if (wr1)
            mem[wr0 ? wp1 : wp_reg] <= d1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + DEPTH_BITS'(nwr);
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (DEPTH_BITS+1)'(nwr) - (DEPTH_BITS+1)'(rd);
        end
    end
endmodule

// File: hdl/ethernet_ipv4_header_parser.sv
// Ethernet/IPv4 header parser, top level. Depends on eihp_pkg, eihp_front, eihp_fifo.
// Throughput: one frame byte per cycle while the result queue has room; full rises
// once the queue holds more than four records (room kept for the byte in flight).
// Path: an accepted byte is held in the capture register, the front end writes its
// records into the queue from there, and they can be popped once the queue write
// has taken place.
// Reset: asynchronous active low; clears parser state and the queue, and sets
// max_ip_length to 3000.
`timescale 1ns / 1ps
module ethernet_ipv4_header_parser #(
    parameter int POSITION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   frame_byte,
    input  logic         frame_end,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output logic         empty,
    input  logic         pop,
    output logic         is_summary,
    output logic [7:0]   text_char,
    output logic [2:0]   packet_type,
    output logic [47:0]  mac_first,
    output logic [47:0]  mac_second,
    output logic [47:0]  arp_hw_addr,
    output logic [31:0]  ip_source,
    output logic [31:0]  ip_target,
    output logic [7:0]   protocol,
    output logic [31:0]  ports,
    output logic [31:0]  ident_frag,
    output logic [4:0]   flags
);
    import eihp_pkg::*;

    logic [15:0] maxlen_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            maxlen_reg <= MAX_IP_RESET;
        else if (cfg_valid)
            maxlen_reg <= cfg_data;
    end

    // Stage 1: the byte is registered, then parsed by the front end.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       take;
    logic       afull;

    assign full = afull;
    assign take = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= take;
    end
    always_ff @(posedge clk)
    begin
        s1_byte_reg <= frame_byte;
        s1_end_reg  <= frame_end;
    end

    logic    tv, sv;
    result_t trec, srec;

    eihp_front #(.POSITION_BITS(POSITION_BITS)) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (s1_valid_reg),
        .frame_byte    (s1_byte_reg),
        .frame_end     (s1_end_reg),
        .max_ip_length (maxlen_reg),
        .text_valid    (tv),
        .text_rec      (trec),
        .sum_valid     (sv),
        .sum_rec       (srec)
    );

    logic    ne;
    result_t q;

    eihp_fifo #(.DEPTH_BITS(3)) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr0         (tv),
        .d0          (trec),
        .wr1         (sv),
        .d1          (srec),
        .rd          (pop && ne),
        .nonempty    (ne),
        .almost_full (afull),
        .q           (q)
    );

    assign empty       = !ne;
    assign is_summary  = q.is_summary;
    assign text_char   = q.text_char;
    assign packet_type = q.packet_type;
    assign mac_first   = q.mac_first;
    assign mac_second  = q.mac_second;
    assign arp_hw_addr = q.arp_hw_addr;
    assign ip_source   = q.ip_source;
    assign ip_target   = q.ip_target;
    assign protocol    = q.protocol;
    assign ports       = q.ports;
    assign ident_frag  = q.ident_frag;
    assign flags       = q.flags;

    // A summary record never carries a text character.
    assert property (@(posedge clk) disable iff (!rst_n)
        sv |-> srec.text_char == 8'h00 && srec.is_summary)
        else $error("summary carries text");
    // Text records carry nothing but the character.
    assert property (@(posedge clk) disable iff (!rst_n)
        tv |-> !trec.is_summary && trec.packet_type == PT_UNKNOWN)
        else $error("text record carries fields");
    // Nothing is written to the queue without an accepted byte in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tv || sv) |-> $past(take))
        else $error("record without input");
endmodule
